// ----- design/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder package
// Item types, the per-item result group that the front and back parts share,
// and the character codes that the front part uses.
// ----------------------------------------------------------------------------
package upd_pkg;

  // Input item: one encoded byte and its end-of-string flag
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // Result item: one decoded byte and its end-of-string flag
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // Number of result bytes one input item can produce
  localparam int unsigned GrpMax = 3;
  localparam int unsigned CntW   = $clog2(GrpMax + 1);

  // All results of one input item; last applies to the final byte only
  typedef struct packed {
    logic [CntW-1:0]          cnt;
    logic                     last;
    logic [GrpMax-1:0][7:0]   bytes;
  } grp_t;

  // What the front part holds between items
  typedef enum logic [1:0] {
    HOLD_NONE  = 2'd0,
    HOLD_PCT   = 2'd1,
    HOLD_DIGIT = 2'd2
  } hold_e;

  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSpace = 8'h20;

endpackage

// ----- design/upd_front.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder front part
// Accepts encoded bytes, tracks a pending percent escape and turns each item
// into a group of zero to three result bytes for the queue.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  upd_pkg::in_item_t in_item_i,
  output logic             grp_push_o,
  output upd_pkg::grp_t    grp_o,
  input  logic             grp_full_i
);
  import upd_pkg::*;

  function automatic logic is_hex(input logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (b inside {[8'h30:8'h39]}) begin
      v = b - 8'h30;
    end else if (b inside {[8'h61:8'h66]}) begin
      v = b - 8'h57;
    end else if (b inside {[8'h41:8'h46]}) begin
      v = b - 8'h37;
    end
    return v[3:0];
  endfunction

  // Bytes that must stay escaped-as-is: alphanumerics and reserved marks
  function automatic logic is_safe(input logic [7:0] v);
    return v inside {[8'h30:8'h39], [8'h61:8'h7A], [8'h41:8'h5A], [8'h26:8'h2F],
                     8'h21, 8'h24, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5F};
  endfunction

  hold_e      hold_q, hold_d;
  logic [7:0] digit_q, digit_d;

  logic       accept;
  logic [7:0] b;
  logic       last;
  logic       b_hex;
  logic [7:0] dec_val;
  logic       fr_hold;
  logic [7:0] fr_byte;
  grp_t       grp;

  assign full   = grp_full_i;
  assign accept = push && !grp_full_i;
  assign b      = in_item_i.in_byte;
  assign last   = in_item_i.in_last;
  assign b_hex  = is_hex(b);
  assign dec_val = {hex_val(digit_q), hex_val(b)};

  // Plain handling of a byte with nothing pending
  assign fr_hold = (b == CharPct) && !last;
  assign fr_byte = (b == CharPlus) ? CharSpace : b;

  // Classify the byte against the pending escape
  always_comb begin
    grp       = '0;
    grp.last  = last;
    hold_d    = HOLD_NONE;
    digit_d   = digit_q;
    case (hold_q)
      HOLD_PCT: begin
        grp.bytes[0] = CharPct;
        if (b_hex) begin
          if (last) begin
            grp.bytes[1] = b;
            grp.cnt      = CntW'(2);
          end else begin
            grp.cnt = CntW'(0);
            hold_d  = HOLD_DIGIT;
            digit_d = b;
          end
        end else if (fr_hold) begin
          grp.cnt = CntW'(1);
          hold_d  = HOLD_PCT;
        end else begin
          grp.bytes[1] = fr_byte;
          grp.cnt      = CntW'(2);
        end
      end
      HOLD_DIGIT: begin
        if (b_hex && !is_safe(dec_val)) begin
          grp.bytes[0] = dec_val;
          grp.cnt      = CntW'(1);
        end else begin
          grp.bytes[0] = CharPct;
          grp.bytes[1] = digit_q;
          if (b_hex) begin
            grp.bytes[2] = b;
            grp.cnt      = CntW'(3);
          end else if (fr_hold) begin
            grp.cnt = CntW'(2);
            hold_d  = HOLD_PCT;
          end else begin
            grp.bytes[2] = fr_byte;
            grp.cnt      = CntW'(3);
          end
        end
      end
      default: begin
        if (fr_hold) begin
          grp.cnt = CntW'(0);
          hold_d  = HOLD_PCT;
        end else begin
          grp.bytes[0] = fr_byte;
          grp.cnt      = CntW'(1);
        end
      end
    endcase
  end

  // Forward only groups that carry results
  assign grp_push_o = accept && (grp.cnt != '0);
  assign grp_o      = grp;

  // Advance the escape state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= HOLD_NONE;
      digit_q <= 8'h00;
    end else if (accept) begin
      hold_q  <= hold_d;
      digit_q <= digit_d;
    end
  end

endmodule

// ----- design/upd_queue.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder group queue
// Short FIFO of result groups between the front and back parts.
// ----------------------------------------------------------------------------
module upd_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  upd_pkg::grp_t wr_grp_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output upd_pkg::grp_t rd_grp_o,
  output logic          empty_o
);
  import upd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CnW  = $clog2(Depth + 1);

  grp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CnW-1:0]  count_q;
  logic            do_wr, do_rd;

  assign full_o   = (count_q == CnW'(Depth));
  assign empty_o  = (count_q == '0);
  assign do_wr    = wr_en_i && !full_o;
  assign do_rd    = rd_en_i && !empty_o;
  assign rd_grp_o = mem_q[rd_ptr_q];

  // Store an incoming group
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_grp_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- design/upd_back.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder back part
// Walks the oldest queued group one byte per popped item and releases the
// group after its final byte.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  upd_pkg::grp_t     grp_i,
  input  logic              grp_empty_i,
  output logic              grp_rd_o,
  output logic              empty,
  input  logic              pop,
  output upd_pkg::out_item_t out_item_o
);
  import upd_pkg::*;

  logic [CntW-1:0] idx_q;
  logic            at_end;
  logic            take;

  assign empty  = grp_empty_i;
  assign take   = pop && !grp_empty_i;
  assign at_end = (idx_q == grp_i.cnt - 1'b1);

  // Present the current byte of the head group
  assign out_item_o.out_byte = grp_i.bytes[idx_q[$clog2(GrpMax)-1:0]];
  assign out_item_o.out_last = grp_i.last && at_end;
  assign grp_rd_o            = take && at_end;

  // Step through the group, restart on release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      idx_q <= at_end ? '0 : idx_q + 1'b1;
    end
  end

endmodule

// ----- design/url_percent_decoder.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder of percent escapes and plus signs, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive in_item_i and raise push; the item is taken on a
//   clock edge where full is low. Output queue side: while empty is low the
//   oldest decoded byte sits on out_item_o; raise pop to take it.
//   Each input item yields zero to three result items. Bytes of a pending
//   escape are held inside until the escape resolves or the string ends.
// Path: each result group is written into the group queue, and out_item_o
//   reads its bytes from the oldest queued group.
// Throughput: one input item per cycle while pop stays high and items yield at
//   most one result each. An item yielding k results keeps the back part busy
//   for k pops; the QueueDepth-entry group queue absorbs that before full rises.
// Reset: clears the pending escape and empties the queue.
// Stall: when pop stays low the queue fills and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  upd_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output upd_pkg::out_item_t out_item_o
);
  import upd_pkg::*;

  logic grp_push, grp_full;
  logic grp_rd, grp_empty;
  grp_t grp_wr, grp_rd_data;

  // Classify incoming bytes
  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .grp_push_o (grp_push),
    .grp_o      (grp_wr),
    .grp_full_i (grp_full)
  );

  // Decouple front and back
  upd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (grp_push),
    .wr_grp_i (grp_wr),
    .full_o   (grp_full),
    .rd_en_i  (grp_rd),
    .rd_grp_o (grp_rd_data),
    .empty_o  (grp_empty)
  );

  // Serialize groups into result items
  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (grp_rd_data),
    .grp_empty_i (grp_empty),
    .grp_rd_o    (grp_rd),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- design/upd_checker.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder port checker
// Watches the top-level ports for queue behavior and result production.
// ----------------------------------------------------------------------------
module upd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input upd_pkg::in_item_t  in_item_i,
  input logic               empty,
  input logic               pop,
  input upd_pkg::out_item_t out_item_o
);
  import upd_pkg::*;

  // Nothing is waiting right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty)
    else $error("result shown right after reset");

  // Backpressure only when results are queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full && empty))
    else $error("full raised with no result waiting");

  // The final byte of a string always yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && in_item_i.in_last) |=> !empty)
    else $error("end of string produced no result");

  // A waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed before pop");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .in_item_i  (in_item_i),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
